// ===== hw/rtl/fpbq_pkg.sv =====
package fpbq_pkg;

	// Fixed widths of the register and output formats.
	localparam int COEF_W = 16;
	localparam int RAW_W  = 32;

	// Default fixed-point format.
	localparam int FRAC_BITS_DEF   = 10;
	localparam int SAMPLE_BITS_DEF = 10;

	// Configuration register map.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

	// Coefficient values after reset (Q10).
	localparam logic signed [COEF_W-1:0] B0_RST = 16'sd1;
	localparam logic signed [COEF_W-1:0] B1_RST = 16'sd2;
	localparam logic signed [COEF_W-1:0] B2_RST = 16'sd1;
	localparam logic signed [COEF_W-1:0] A1_RST = -16'sd1978;
	localparam logic signed [COEF_W-1:0] A2_RST = 16'sd958;

endpackage

// ===== hw/rtl/fixed_point_biquad_lowpass.sv =====
// Second-order low-pass IIR section in direct form I. Each input transaction carries one
// unsigned converter sample, which is scaled to Q(FRAC_BITS) and filtered with the five
// signed Q(FRAC_BITS) coefficients held in the configuration registers (indices 0 to 4:
// b0, b1, b2, a1, a2; writes to higher indices are dropped). Each input transaction
// produces exactly one output transaction carrying the Q output raw_q (saturated to
// 32 bits), its integer part clamped to the sample range as level, and a clipped flag.
// The block accepts one sample per cycle unless a full output register is stalled, and
// result is registered on acceptance; the cycle time is set by the feedback from the
// output history through the a1 multiplier and five-input adder back into the history
// registers. Coefficients should only be written while no transaction is in flight.
module fixed_point_biquad_lowpass #(
	parameter int FRAC_BITS   = fpbq_pkg::FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = fpbq_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Sample input channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [SAMPLE_BITS-1:0]               sample,
	// Result output channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [SAMPLE_BITS-1:0]               level,
	output logic signed [fpbq_pkg::RAW_W-1:0]    raw_q,
	output logic                                 clipped,
	// Coefficient write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fpbq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fpbq_pkg::COEF_W-1:0]          cfg_data
);

	localparam int COEF_W = fpbq_pkg::COEF_W;
	localparam int RAW_W  = fpbq_pkg::RAW_W;
	// A scaled sample with a leading zero so that it multiplies as a signed value.
	localparam int XW     = SAMPLE_BITS + FRAC_BITS + 1;
	localparam int XP_W   = COEF_W + XW;
	localparam int YP_W   = COEF_W + RAW_W;
	// Five products need three bits of growth, so the sum can never wrap.
	localparam int ACC_W  = ((XP_W > YP_W) ? XP_W : YP_W) + 3;

	localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
	localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};

	logic signed [COEF_W-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;

	// Filter history: the two previous samples and the two previous saturated outputs.
	logic [SAMPLE_BITS-1:0]   prev_in_one_q, prev_in_two_q;
	logic signed [RAW_W-1:0]  prev_out_one_q, prev_out_two_q;

	logic signed [XW-1:0]     x0, x1, x2;
	logic signed [XP_W-1:0]   p_b0, p_b1, p_b2;
	logic signed [YP_W-1:0]   p_a1, p_a2;
	logic signed [ACC_W-1:0]  acc, acc_shift;
	logic [ACC_W-RAW_W:0]     acc_hi;
	logic                     acc_ovf;
	logic signed [RAW_W-1:0]  y_sat;
	logic [RAW_W-1:0]         y_int;
	logic [SAMPLE_BITS-1:0]   level_next;
	logic                     clip_next;
	logic                     in_accept;

	// The output register is the only buffer. A new sample is taken whenever that
	// register is empty or is being emptied in the same cycle, so the input side
	// only waits while the downstream side is stalling a full register.
	assign in_stall  = out_valid && out_stall;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Coefficient registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q <= fpbq_pkg::B0_RST;
			coef_b1_q <= fpbq_pkg::B1_RST;
			coef_b2_q <= fpbq_pkg::B2_RST;
			coef_a1_q <= fpbq_pkg::A1_RST;
			coef_a2_q <= fpbq_pkg::A2_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fpbq_pkg::REG_B0: coef_b0_q <= cfg_data;
				fpbq_pkg::REG_B1: coef_b1_q <= cfg_data;
				fpbq_pkg::REG_B2: coef_b2_q <= cfg_data;
				fpbq_pkg::REG_A1: coef_a1_q <= cfg_data;
				fpbq_pkg::REG_A2: coef_a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Inputs scaled to Q(FRAC_BITS); the top bit is always zero.
	assign x0 = {1'b0, sample,        {FRAC_BITS{1'b0}}};
	assign x1 = {1'b0, prev_in_one_q, {FRAC_BITS{1'b0}}};
	assign x2 = {1'b0, prev_in_two_q, {FRAC_BITS{1'b0}}};

	assign p_b0 = coef_b0_q * x0;
	assign p_b1 = coef_b1_q * x1;
	assign p_b2 = coef_b2_q * x2;
	assign p_a1 = coef_a1_q * prev_out_one_q;
	assign p_a2 = coef_a2_q * prev_out_two_q;

	assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
	           - ACC_W'(p_a1) - ACC_W'(p_a2);

	// The arithmetic shift rounds towards minus infinity, as the filter is specified.
	assign acc_shift = acc >>> FRAC_BITS;

	// The shifted sum fits in RAW_W bits only when all bits above the sign agree.
	assign acc_hi  = acc_shift[ACC_W-1:RAW_W-1];
	assign acc_ovf = !((&acc_hi) || !(|acc_hi));

	always_comb begin
		if (acc_ovf) begin
			y_sat = acc_shift[ACC_W-1] ? RAW_MIN : RAW_MAX;
		end else begin
			y_sat = acc_shift[RAW_W-1:0];
		end
	end

	// Integer part of a non-negative output, used for the clamped level.
	assign y_int = {{FRAC_BITS{1'b0}}, y_sat[RAW_W-1:FRAC_BITS]};

	always_comb begin
		if (y_sat[RAW_W-1]) begin
			level_next = '0;
			clip_next  = 1'b1;
		end else if (|y_int[RAW_W-1:SAMPLE_BITS]) begin
			level_next = '1;
			clip_next  = 1'b1;
		end else begin
			level_next = y_int[SAMPLE_BITS-1:0];
			clip_next  = 1'b0;
		end
	end

	// History moves on only when a sample is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_in_one_q  <= '0;
			prev_in_two_q  <= '0;
			prev_out_one_q <= '0;
			prev_out_two_q <= '0;
		end else if (in_accept) begin
			prev_in_one_q  <= sample;
			prev_in_two_q  <= prev_in_one_q;
			prev_out_one_q <= y_sat;
			prev_out_two_q <= prev_out_one_q;
		end
	end

	// Output register: its valid flag is control state, the payload is not reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			level   <= level_next;
			raw_q   <= y_sat;
			clipped <= clip_next;
		end
	end

endmodule

// ===== hw/rtl/fpbq_checker.sv =====
module fpbq_checker #(
	parameter int FRAC_BITS   = fpbq_pkg::FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = fpbq_pkg::SAMPLE_BITS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [SAMPLE_BITS-1:0]               level,
	input logic signed [fpbq_pkg::RAW_W-1:0]    raw_q,
	input logic                                 clipped
);

	// A stalled result stays presented.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Every accepted sample shows a result in the following cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted sample gave no result");

	// With the output register empty the input side never waits.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output register");

	// A negative output clamps to zero.
	a_neg_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && raw_q[fpbq_pkg::RAW_W-1] |-> clipped && (level == '0))
		else $error("negative output not clamped to zero");

	// An unclipped level is the integer part of the Q output.
	a_level_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !clipped |-> level == raw_q[FRAC_BITS +: SAMPLE_BITS])
		else $error("level does not match the Q output");

endmodule

bind fixed_point_biquad_lowpass fpbq_checker #(
	.FRAC_BITS   (FRAC_BITS),
	.SAMPLE_BITS (SAMPLE_BITS)
) u_fpbq_checker (.*);
